### src/sdf_pkg.sv
// Shared constants, codes and types of the signed decimal field formatter.
`timescale 1ns / 1ps

package sdf_pkg;

   localparam int VALUE_W           = 64;
   localparam int CHAR_W            = 8;
   localparam int DIGITS            = 20;
   localparam int DIGIT_IDX_W       = 5;
   localparam int COUNT_W           = 5;
   localparam int SHIFT_CNT_W       = 6;
   localparam int POS_W             = 7;
   localparam int FIELD_W           = 6;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 6;
   localparam int MAX_FIELD_DEFAULT = 63;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_WIDTH     = 3'd0,
      CSR_MIN_DIGITS      = 3'd1,
      CSR_PRECISION_GIVEN = 3'd2,
      CSR_LEFT_JUSTIFY    = 3'd3,
      CSR_FORCE_PLUS      = 3'd4,
      CSR_SPACE_SIGN      = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic measure;
      logic layout;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic last_shift;
      logic out_free;
      logic last_char;
      logic total_zero;
   } dp_status_type;

endpackage

### src/sdf_channels_if.sv
// Handshake channels of the formatter: input word, output character and register write.
`timescale 1ns / 1ps

interface sdf_req_if
   import sdf_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sdf_rsp_if
   import sdf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

interface sdf_csr_if
   import sdf_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### src/sdf_ctrl.sv
// Sequencer of the formatter: conversion, measuring, layout and character emission.
`timescale 1ns / 1ps

module sdf_ctrl
   import sdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.last_shift) state_in = ST_MEASURE;
         end
         ST_MEASURE: begin
            state_in = ST_LAYOUT;
         end
         ST_LAYOUT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // An empty field leaves without emitting anything.
            if (status.total_zero) begin
               state_in = ST_IDLE;
            end else if (status.out_free && status.last_char) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
         end
         ST_LAYOUT: begin
            cmd.layout = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free && !status.total_zero;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### src/sdf_datapath.sv
// Datapath of the formatter: registers, binary to decimal converter, layout and output stage.
`timescale 1ns / 1ps

module sdf_datapath
   import sdf_pkg::*;
#(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CHAR_W-1:0]         rsp_out_char,
   output logic                      rsp_last
);

   localparam logic [7:0] MaxField = 8'(MAX_FIELD);

   // Configuration registers
   logic [FIELD_W-1:0] field_width_ff;
   logic [FIELD_W-1:0] min_digits_ff;
   logic               precision_given_ff;
   logic               left_justify_ff;
   logic               force_plus_ff;
   logic               space_sign_ff;

   // Conversion state
   logic [VALUE_W-1:0]     bin_ff, bin_in;
   bcd_type                bcd_ff, bcd_in, bcd_adj;
   logic [SHIFT_CNT_W-1:0] shift_cnt_ff, shift_cnt_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_W-1:0]     digit_count_ff, digit_count_in;

   // Layout of the field, as character positions
   logic [POS_W-1:0]  b_pad_ff, b_pad_in;
   logic [POS_W-1:0]  b_sign_ff, b_sign_in;
   logic [POS_W-1:0]  b_zero_ff, b_zero_in;
   logic [POS_W-1:0]  b_dig_ff, b_dig_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [CHAR_W-1:0] sign_char_ff, sign_char_in;
   logic [POS_W-1:0]  emit_position_ff, emit_position_in;

   // Output stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              last_ff, last_in;

   logic [COUNT_W-1:0]     ndig_found;
   logic [FIELD_W-1:0]     prec_cap;
   logic [FIELD_W-1:0]     width_cap;
   logic [POS_W-1:0]       prec7, ndig7, zeros, body, width7, pad, sign7;
   logic                   has_sign;
   logic [POS_W-1:0]       dig_off;
   logic [DIGIT_IDX_W-1:0] dig_idx;
   logic [CHAR_W-1:0]      next_char;
   logic                   out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff     <= '0;
         min_digits_ff      <= '0;
         precision_given_ff <= 1'b0;
         left_justify_ff    <= 1'b0;
         force_plus_ff      <= 1'b0;
         space_sign_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FIELD_WIDTH:     field_width_ff     <= csr_data;
            CSR_MIN_DIGITS:      min_digits_ff      <= csr_data;
            CSR_PRECISION_GIVEN: precision_given_ff <= csr_data[0];
            CSR_LEFT_JUSTIFY:    left_justify_ff    <= csr_data[0];
            CSR_FORCE_PLUS:      force_plus_ff      <= csr_data[0];
            CSR_SPACE_SIGN:      space_sign_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Double dabble: add three to every digit of five or more, then shift in one bit.
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         bcd_adj[k] = (bcd_ff[k] >= 4'd5) ? bcd_ff[k] + 4'd3 : bcd_ff[k];
      end
   end

   always_comb begin
      ndig_found = '0;
      for (int k = 0; k < DIGITS; k++) begin
         if (bcd_ff[k] != 4'd0) ndig_found = COUNT_W'(k + 1);
      end
   end

   always_comb begin
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      shift_cnt_in   = shift_cnt_ff;
      neg_in         = neg_ff;
      digit_count_in = digit_count_ff;
      if (cmd.load) begin
         neg_in       = req_value[VALUE_W-1];
         // The most negative value negates to its own unsigned magnitude.
         bin_in       = req_value[VALUE_W-1] ? (~req_value + 1'b1) : req_value;
         bcd_in       = '0;
         shift_cnt_in = '0;
      end else if (cmd.shift) begin
         // The top digit of a 64-bit magnitude never exceeds one, so its upper bit is free.
         bcd_in       = {bcd_adj[DIGITS-1][2:0], bcd_adj[DIGITS-2:0], bin_ff[VALUE_W-1]};
         bin_in       = {bin_ff[VALUE_W-2:0], 1'b0};
         shift_cnt_in = shift_cnt_ff + 1'b1;
      end else if (cmd.measure) begin
         // Zero prints one digit unless an explicit precision of zero was given.
         if (ndig_found == '0 && !(precision_given_ff && min_digits_ff == '0)) begin
            digit_count_in = COUNT_W'(1);
         end else begin
            digit_count_in = ndig_found;
         end
      end
   end

   always_comb begin
      width_cap = ({2'b00, field_width_ff} > MaxField) ? MaxField[FIELD_W-1:0] : field_width_ff;
      prec_cap  = ({2'b00, min_digits_ff} > MaxField) ? MaxField[FIELD_W-1:0] : min_digits_ff;
      prec7     = precision_given_ff ? {1'b0, prec_cap} : '0;
      ndig7     = {2'b00, digit_count_ff};
      zeros     = (prec7 > ndig7) ? prec7 - ndig7 : '0;
      has_sign  = neg_ff || force_plus_ff || space_sign_ff;
      sign7     = {{(POS_W-1){1'b0}}, has_sign};
      body      = ndig7 + zeros + sign7;
      width7    = {1'b0, width_cap};
      pad       = (width7 > body) ? width7 - body : '0;
      b_pad_in  = left_justify_ff ? '0 : pad;
      b_sign_in = b_pad_in + sign7;
      b_zero_in = b_sign_in + zeros;
      b_dig_in  = b_zero_in + ndig7;
      total_in  = b_dig_in + (left_justify_ff ? pad : '0);
      if (neg_ff) begin
         sign_char_in = CHAR_MINUS;
      end else if (force_plus_ff) begin
         sign_char_in = CHAR_PLUS;
      end else begin
         sign_char_in = CHAR_SPACE;
      end
   end

   always_comb begin
      dig_off = b_dig_ff - 7'd1 - emit_position_ff;
      dig_idx = dig_off[DIGIT_IDX_W-1:0];
      if (emit_position_ff < b_pad_ff) begin
         next_char = CHAR_SPACE;
      end else if (emit_position_ff < b_sign_ff) begin
         next_char = sign_char_ff;
      end else if (emit_position_ff < b_zero_ff) begin
         next_char = CHAR_ZERO;
      end else if (emit_position_ff < b_dig_ff) begin
         next_char = CHAR_ZERO + {4'b0000, bcd_ff[dig_idx]};
      end else begin
         next_char = CHAR_SPACE;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      emit_position_in = emit_position_ff;
      rsp_valid_in     = rsp_valid_ff;
      out_char_in      = out_char_ff;
      last_in          = last_ff;
      if (cmd.layout) begin
         emit_position_in = '0;
      end
      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         out_char_in      = next_char;
         last_in          = status.last_char;
         emit_position_in = emit_position_ff + 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff   <= '0;
         emit_position_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         shift_cnt_ff     <= '0;
         total_ff         <= '0;
      end else begin
         digit_count_ff   <= digit_count_in;
         emit_position_ff <= emit_position_in;
         rsp_valid_ff     <= rsp_valid_in;
         shift_cnt_ff     <= shift_cnt_in;
         if (cmd.layout) total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
      if (cmd.layout) begin
         b_pad_ff     <= b_pad_in;
         b_sign_ff    <= b_sign_in;
         b_zero_ff    <= b_zero_in;
         b_dig_ff     <= b_dig_in;
         sign_char_ff <= sign_char_in;
      end
   end

   always_comb begin
      status.last_shift = (shift_cnt_ff == '1);
      status.out_free   = out_free;
      status.last_char  = (emit_position_ff == total_ff - 7'd1);
      status.total_zero = (total_ff == '0);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = last_ff;

endmodule

### src/signed_decimal_field_formatter_top.sv
// Top level of the signed decimal field formatter (printf %d conversion).
//
// Usage: configuration registers are written on csr_if (index, data), which is
// always ready; writes must go in only while the block is idle, and the block itself
// does not enforce this. Each word accepted on req_if carries one signed 64-bit value.
// The formatted text leaves on rsp_if as ASCII characters, most significant first,
// with last set on the final one. An empty field produces no output words at all.
// Sequence: after acceptance the binary to decimal converter shifts through all 64
// bits (one bit per cycle), then the measure state finds the digit count and the
// layout state lays out the field; the emit state then loads each character into
// the output register. Characters leave one per cycle while the receiver is ready,
// at most 64 of them per value. The shift-and-add converter sets the conversion time.
// The block takes one value at a time; req_if.ready is high only when idle.
// The output register lets the next value be accepted while the final
// character still waits. A stalled receiver holds the current character and
// pauses emission without losing state. Reset (synchronous, active high)
// clears the sequencer, the counters and the configuration registers and
// empties the output stage.
`timescale 1ns / 1ps

module signed_decimal_field_formatter_top
   import sdf_pkg::*;
#(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   sdf_req_if.sink    req_if,
   sdf_rsp_if.source  rsp_if,
   sdf_csr_if.sink    csr_if
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   sdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdf_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_if.value),
      .csr_write    (csr_if.valid),
      .csr_index    (csr_if.index),
      .csr_data     (csr_if.data),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_out_char (rsp_if.out_char),
      .rsp_last     (rsp_if.last)
   );

`ifndef NO_ASSERTIONS
   // Once a word is taken the block stays busy for the conversion.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_ready |=> !req_ready)
      else $error("input accepted again right after an accepted word");

   // Emission never overlaps conversion or input acceptance.
   a_emit_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !req_ready && !cmd.shift)
      else $error("character emitted while converting or idle");

   // The layout follows in the cycle after the digit count is measured.
   a_measure_then_layout: assert property (@(posedge clock) disable iff (reset)
      cmd.measure |=> cmd.layout)
      else $error("layout did not follow the digit measurement");

   // The last character of a field is the one that ends the emission.
   a_last_ends_field: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.last_char |=> !cmd.emit)
      else $error("emission continued past the last character");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench of the signed decimal field formatter: %d text of 64-bit values.
`timescale 1ns / 1ps

module tb_top;
   import sdf_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int FIELD_CAP      = 64;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } field_char_type;

   logic clock;
   logic reset;

   sdf_req_if req_if ();
   sdf_rsp_if rsp_if ();
   sdf_csr_if csr_if ();

   signed_decimal_field_formatter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Local copy of the format registers, updated when a write is accepted.
   logic [FIELD_W-1:0] fmt_width;
   logic [FIELD_W-1:0] fmt_min_digits;
   logic               fmt_prec_given;
   logic               fmt_left_justify;
   logic               fmt_force_plus;
   logic               fmt_space_sign;

   field_char_type expected_chars[$];
   field_char_type oldest_char;

   int send_idle_pct;
   int recv_idle_pct;
   int recv_hold;
   int idle_cycles;
   int mismatches;
   int values_sent;
   int chars_checked;
   int empty_fields;
   int reg_writes;

   always #2 clock = ~clock;

   // Builds the expected text of one value under the current format.
   function automatic void predict_field(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digit [DIGITS];
      logic [CHAR_W-1:0]  text [FIELD_CAP + 8];
      logic [CHAR_W-1:0]  sign_ch;
      int                 has_sign;
      int                 ndig;
      int                 prec;
      int                 zeros;
      int                 body;
      int                 pad;
      int                 n;
      int                 i;
      field_char_type     fc;
      mag  = v[VALUE_W-1] ? -v : v;
      ndig = 0;
      while (mag != 0 && ndig < DIGITS) begin
         digit[ndig] = 4'(mag % 10);
         mag = mag / 10;
         ndig++;
      end
      if (ndig == 0 && !(fmt_prec_given && fmt_min_digits == 0)) begin
         digit[0] = 4'd0;
         ndig = 1;
      end
      prec  = fmt_prec_given ? int'(fmt_min_digits) : 0;
      zeros = (prec > ndig) ? prec - ndig : 0;
      has_sign = 1;
      sign_ch  = CHAR_SPACE;
      if (v[VALUE_W-1]) begin
         sign_ch = CHAR_MINUS;
      end else if (fmt_force_plus) begin
         sign_ch = CHAR_PLUS;
      end else if (!fmt_space_sign) begin
         has_sign = 0;
      end
      body = ndig + zeros + has_sign;
      pad  = (int'(fmt_width) > body) ? int'(fmt_width) - body : 0;
      n = 0;
      if (!fmt_left_justify) begin
         for (i = 0; i < pad && n < FIELD_CAP; i++) text[n++] = CHAR_SPACE;
      end
      if (has_sign != 0 && n < FIELD_CAP) text[n++] = sign_ch;
      for (i = 0; i < zeros && n < FIELD_CAP; i++) text[n++] = CHAR_ZERO;
      for (i = ndig; i > 0 && n < FIELD_CAP; i--) text[n++] = CHAR_ZERO + 8'(digit[i-1]);
      if (fmt_left_justify) begin
         for (i = 0; i < pad && n < FIELD_CAP; i++) text[n++] = CHAR_SPACE;
      end
      for (i = 0; i < n; i++) begin
         fc.ch   = text[i];
         fc.last = (i == n - 1);
         expected_chars.push_back(fc);
      end
      if (n == 0) empty_fields++;
   endfunction

   // Mostly awkward values: extremes, powers of ten and their neighbors, short numbers.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      int                 k;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: v = 64'($urandom_range(999));
         1: begin
            v = 64'd1;
            for (k = $urandom_range(18); k > 0; k--) v = v * 10;
            v = v + 64'($urandom_range(2)) - 64'd1;
         end
         2: begin
            case ($urandom_range(4))
               0: v = 64'h8000_0000_0000_0000;
               1: v = 64'h7FFF_FFFF_FFFF_FFFF;
               2: v = '0;
               3: v = '1;
               default: v = 64'd1;
            endcase
         end
         3: v = v >> $urandom_range(63);
         default: ;
      endcase
      if ($urandom_range(3) == 0) v = -v;
      return v;
   endfunction

   task automatic send_value(logic [VALUE_W-1:0] v);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      predict_field(v);
      values_sent++;
   endtask

   // Lets the block run dry: no word owed and no conversion still running.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= wdata;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_FIELD_WIDTH:     fmt_width        = wdata;
         CSR_MIN_DIGITS:      fmt_min_digits   = wdata;
         CSR_PRECISION_GIVEN: fmt_prec_given   = wdata[0];
         CSR_LEFT_JUSTIFY:    fmt_left_justify = wdata[0];
         CSR_FORCE_PLUS:      fmt_force_plus   = wdata[0];
         CSR_SPACE_SIGN:      fmt_space_sign   = wdata[0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_format(int width, int digits, bit prec, bit left, bit plus, bit space);
      wait_idle();
      write_reg(CSR_FIELD_WIDTH, CSR_DATA_W'(width));
      write_reg(CSR_MIN_DIGITS, CSR_DATA_W'(digits));
      write_reg(CSR_PRECISION_GIVEN, CSR_DATA_W'(prec));
      write_reg(CSR_LEFT_JUSTIFY, CSR_DATA_W'(left));
      write_reg(CSR_FORCE_PLUS, CSR_DATA_W'(plus));
      write_reg(CSR_SPACE_SIGN, CSR_DATA_W'(space));
   endtask

   task automatic test_reset_format();
      send_value(64'd0);
      send_value(64'd1);
      send_value('1);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'd1234567890);
   endtask

   task automatic test_precision();
      // A precision without its flag must be ignored.
      set_format(0, 5, 0, 0, 0, 0);
      send_value(64'd42);
      set_format(0, 5, 1, 0, 0, 0);
      send_value(64'd42);
      send_value(-64'd42);
      // Zero printed with zero precision has no digit, so this field is empty.
      set_format(0, 0, 1, 0, 0, 0);
      send_value(64'd0);
      send_value(64'd7);
      set_format(3, 0, 1, 0, 0, 0);
      send_value(64'd0);
      set_format(0, 0, 1, 0, 1, 0);
      send_value(64'd0);
   endtask

   task automatic test_sign_and_padding();
      set_format(8, 0, 0, 0, 1, 1);
      send_value(64'd5);
      send_value(-64'd5);
      send_value(64'd0);
      set_format(8, 0, 0, 1, 0, 1);
      send_value(64'd5);
      send_value(-64'd5);
   endtask

   task automatic test_field_extremes();
      // Widest field: 63 zero-padded digits plus a sign makes 64 characters.
      set_format(63, 63, 1, 0, 1, 0);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      set_format(63, 63, 1, 1, 0, 1);
      send_value(64'd0);
      send_value(64'h8000_0000_0000_0000);
   endtask

   task automatic test_random_traffic(int send_idle, int recv_idle, int settings, int count);
      int s;
      int k;
      int width;
      int digits;
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      for (s = 0; s < settings; s++) begin
         case ($urandom_range(3))
            0: width = 0;
            1: width = 63;
            default: width = $urandom_range(30);
         endcase
         case ($urandom_range(3))
            0: digits = 0;
            1: digits = 63;
            default: digits = $urandom_range(25);
         endcase
         set_format(width, digits, $urandom_range(1), $urandom_range(1),
                    $urandom_range(1), $urandom_range(1));
         for (k = 0; k < count; k++) send_value(pick_value());
      end
   endtask

   // The receiver stops for a long stretch while values keep coming, so the
   // output stage fills and the block has to refuse new words.
   task automatic test_output_stall();
      int k;
      set_format(12, 4, 1, 0, 0, 1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      recv_hold = HOLD_CYCLES;
      for (k = 0; k < 4; k++) send_value(pick_value());
   endtask

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         rsp_if.ready <= 1'b0;
         recv_hold = recv_hold - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_chars.size() == 0) begin
            $error("out_char: expected nothing, got %h (last %b)", rsp_if.out_char, rsp_if.last);
            mismatches++;
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_if.out_char !== oldest_char.ch) begin
               $error("out_char: expected %h, got %h", oldest_char.ch, rsp_if.out_char);
               mismatches++;
            end
            if (rsp_if.last !== oldest_char.last) begin
               $error("last: expected %b, got %b", oldest_char.last, rsp_if.last);
               mismatches++;
            end
            chars_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.index  = CSR_FIELD_WIDTH;
      csr_if.data   = '0;
      fmt_width        = '0;
      fmt_min_digits   = '0;
      fmt_prec_given   = 1'b0;
      fmt_left_justify = 1'b0;
      fmt_force_plus   = 1'b0;
      fmt_space_sign   = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold     = 0;
      idle_cycles   = 0;
      mismatches    = 0;
      values_sent   = 0;
      chars_checked = 0;
      empty_fields  = 0;
      reg_writes    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_format();
      test_precision();
      test_sign_and_padding();
      test_field_extremes();
      test_random_traffic(30, 83, 5, 15);
      test_random_traffic(83, 30, 5, 15);
      test_random_traffic(0, 0, 5, 15);
      test_output_stall();
      wait_idle();

      if (expected_chars.size() != 0) begin
         $error("last: %0d expected characters never arrived", expected_chars.size());
         mismatches++;
      end
      $display("tb: %0d values formatted, %0d characters checked, %0d empty fields",
               values_sent, chars_checked, empty_fields);
      $display("tb: %0d register writes, width and precision from 0 to 63, all sign modes",
               reg_writes);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
